FILE: rtl/core/fbpa_pkg.sv
package fbpa_pkg;

  // Default pool geometry
  localparam int unsigned POOL_BLOCKS_DEF = 1024;
  localparam int unsigned BLOCK_ALIGN_DEF = 8;
  localparam int unsigned MIN_STRIDE      = 8;

  // Field and register widths
  localparam int unsigned SizeW    = 17;
  localparam int unsigned CountW   = 11;
  localparam int unsigned CfgW     = 17;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned IndexW   = 10;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned OffsetW  = 26;
  // Largest stride: a 17-bit size rounded up to the alignment
  localparam int unsigned StrideW  = 18;

  // Register reset values
  localparam logic [SizeW-1:0]  BLOCK_SIZE_RST  = SizeW'(8);
  localparam logic [CountW-1:0] BLOCK_COUNT_RST = CountW'(1024);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BLOCK_SIZE  = 1'b0,
    CFG_BLOCK_COUNT = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_BAD_INDEX = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_LINK = 1'b1
  } state_e;

  // Stride unit to top level
  typedef struct packed {
    logic               busy;
    logic [StrideW-1:0] stride;
  } stride_t;

endpackage

FILE: rtl/core/fbpa_stride.sv
module fbpa_stride #(
  parameter int unsigned BLOCK_ALIGN = fbpa_pkg::BLOCK_ALIGN_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       restart_i,
  input  logic [fbpa_pkg::SizeW-1:0] block_size_i,
  output fbpa_pkg::stride_t          stride_o
);
  import fbpa_pkg::*;

  // Rounding sum: raised size plus align-1 stays below 2^18
  localparam int unsigned SumW  = 18;
  localparam int unsigned AlgL  = $clog2(BLOCK_ALIGN);
  localparam int unsigned Sh    = SumW + AlgL;
  localparam int unsigned MW    = SumW + 1;
  localparam longint unsigned RecipL =
    ((64'd1 << Sh) + 64'(BLOCK_ALIGN) - 64'd1) / 64'(BLOCK_ALIGN);
  localparam logic [MW-1:0]      Recip  = MW'(RecipL);
  localparam logic [SumW-1:0]    AlignM = SumW'(BLOCK_ALIGN - 1);
  localparam logic [StrideW-1:0] AlignC = StrideW'(BLOCK_ALIGN);
  localparam logic [SizeW-1:0]   MinS   = SizeW'(MIN_STRIDE);

  logic [SumW-1:0]    sum_d, sum_q;
  logic [SumW+MW-1:0] recip_prod;
  logic [SumW-1:0]    quot_d, quot_q;
  logic [SumW+StrideW-1:0] stride_prod;
  logic [StrideW-1:0] stride_d, stride_q;
  logic [1:0]         settle_d, settle_q;

  // Raise to the minimum and add align-1
  always_comb begin
    if (block_size_i < MinS) begin
      sum_d = SumW'(MinS) + AlignM;
    end else begin
      sum_d = SumW'(block_size_i) + AlignM;
    end
  end

  // Divide by the alignment through the reciprocal, then scale back
  assign recip_prod  = sum_q * Recip;
  assign quot_d      = SumW'(recip_prod >> Sh);
  assign stride_prod = quot_q * AlignC;
  assign stride_d    = stride_prod[StrideW-1:0];

  always_ff @(posedge clk_i) begin
    sum_q    <= sum_d;
    quot_q   <= quot_d;
    stride_q <= stride_d;
  end

  // Count down while the three stages settle
  always_comb begin
    if (restart_i) begin
      settle_d = 2'd3;
    end else if (settle_q != 2'd0) begin
      settle_d = settle_q - 2'd1;
    end else begin
      settle_d = settle_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= 2'd3;
    end else begin
      settle_q <= settle_d;
    end
  end

  assign stride_o.busy   = (settle_q != 2'd0);
  assign stride_o.stride = stride_q;

endmodule

FILE: rtl/core/fixed_block_pool_allocator_top.sv
// Free, fresh alloc, empty and bad-index requests: result registered in the
// cycle after acceptance; the next request may be accepted in the following
// cycle unless the output stalls. Alloc from the free list goes through
// S_LINK, where the link memory read yields the new list head; no new request
// is taken there. Reset empties the list; the link memory is not cleared.
// After reset and every config write, input stalls while the stride settles.
module fixed_block_pool_allocator_top #(
  parameter int unsigned POOL_BLOCKS = fbpa_pkg::POOL_BLOCKS_DEF,
  parameter int unsigned BLOCK_ALIGN = fbpa_pkg::BLOCK_ALIGN_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [fbpa_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [fbpa_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         command_i,
  input  logic [fbpa_pkg::IndexW-1:0]  block_index_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [fbpa_pkg::StatusW-1:0] status_o,
  output logic [fbpa_pkg::IndexW-1:0]  granted_index_o,
  output logic [fbpa_pkg::OffsetW-1:0] byte_offset_o
);
  import fbpa_pkg::*;

  localparam int unsigned IdxW  = $clog2(POOL_BLOCKS);
  localparam int unsigned HeadW = $clog2(POOL_BLOCKS + 1);
  localparam int unsigned CntW  = (HeadW > CountW) ? HeadW : CountW;
  localparam int unsigned GW    = (IdxW > IndexW) ? IdxW : IndexW;
  localparam int unsigned ProdW = IdxW + StrideW;
  localparam int unsigned PW    = (ProdW > OffsetW) ? ProdW : OffsetW;
  localparam logic [HeadW-1:0] PoolEnd = HeadW'(POOL_BLOCKS);
  localparam logic [CntW-1:0]  PoolCnt = CntW'(POOL_BLOCKS);

  state_e state_q, state_d;

  logic [SizeW-1:0]  block_size_q;
  logic [CountW-1:0] block_count_q;
  logic [HeadW-1:0]  head_q, head_d;
  logic [HeadW-1:0]  fresh_q, fresh_d;

  logic [HeadW-1:0]  link_mem [POOL_BLOCKS];
  logic [HeadW-1:0]  link_rdata_q;
  logic              mem_we, mem_re;
  logic [IdxW-1:0]   mem_addr;

  stride_t           stride;

  logic              in_acc, out_take, head_ok;
  logic [CntW-1:0]   eff_cnt, idx_ext;

  logic              out_valid_q, out_load;
  status_e           status_q, status_d;
  logic [IdxW-1:0]   granted_q, granted_d;
  logic [OffsetW-1:0] offset_q;
  logic [ProdW-1:0]  offset_prod;
  logic [PW-1:0]     offset_ext;
  logic [GW-1:0]     granted_ext;

  fbpa_stride #(
    .BLOCK_ALIGN(BLOCK_ALIGN)
  ) u_stride (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .restart_i   (cfg_we_i),
    .block_size_i(block_size_q),
    .stride_o    (stride)
  );

  // Handshake and list condition
  assign in_stall_o = (state_q != S_IDLE) || stride.busy || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_q && !out_stall_i;
  assign head_ok    = (head_q < PoolEnd);
  assign eff_cnt    = (CntW'(block_count_q) > PoolCnt) ? PoolCnt : CntW'(block_count_q);
  assign idx_ext    = CntW'(block_index_i);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && (cmd_e'(command_i) == CMD_ALLOC) && head_ok) begin
          state_d = S_LINK;
        end
      end
      S_LINK: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath: pop, push, fresh grant and result
  always_comb begin
    head_d    = head_q;
    fresh_d   = fresh_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = head_q[IdxW-1:0];
    out_load  = 1'b0;
    status_d  = STAT_OK;
    granted_d = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          out_load = 1'b1;
          if (cmd_e'(command_i) == CMD_ALLOC) begin
            if (head_ok) begin
              out_load = 1'b0;
              mem_re   = 1'b1;
            end else if (CntW'(fresh_q) < eff_cnt) begin
              granted_d = fresh_q[IdxW-1:0];
              fresh_d   = fresh_q + HeadW'(1);
            end else begin
              status_d = STAT_EMPTY;
            end
          end else begin
            if (idx_ext >= eff_cnt) begin
              status_d = STAT_BAD_INDEX;
            end else begin
              mem_we   = 1'b1;
              mem_addr = idx_ext[IdxW-1:0];
              head_d   = HeadW'(idx_ext);
            end
          end
        end
      end
      S_LINK: begin
        out_load  = 1'b1;
        granted_d = head_q[IdxW-1:0];
        head_d    = link_rdata_q;
      end
      default: ;
    endcase
    if (cfg_we_i) begin
      head_d  = PoolEnd;
      fresh_d = '0;
    end
  end

  // Link memory, one access per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[mem_addr] <= head_q;
    end
    if (mem_re) begin
      link_rdata_q <= link_mem[mem_addr];
    end
  end

  // Control state and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      head_q        <= PoolEnd;
      fresh_q       <= '0;
      block_size_q  <= BLOCK_SIZE_RST;
      block_count_q <= BLOCK_COUNT_RST;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      fresh_q <= fresh_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_BLOCK_SIZE:  block_size_q  <= cfg_data_i[SizeW-1:0];
          CFG_BLOCK_COUNT: block_count_q <= cfg_data_i[CountW-1:0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Offset of the granted block; zero index gives zero offset
  assign offset_prod = granted_d * stride.stride;
  assign offset_ext  = PW'(offset_prod);

  // Hold the result payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_q  <= status_d;
      granted_q <= granted_d;
      offset_q  <= offset_ext[OffsetW-1:0];
    end
  end

  assign granted_ext     = GW'(granted_q);
  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign granted_index_o = granted_ext[IndexW-1:0];
  assign byte_offset_o   = offset_q;

  // A list pop only starts with the output register empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LINK) |-> !out_valid_q)
    else $error("output register busy during list pop");

  // No request is taken while the stride settles
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stride.busy |-> !in_acc)
    else $error("request accepted while stride unsettled");

  // An alloc with a listed head reads the link and then completes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (cmd_e'(command_i) == CMD_ALLOC) && head_ok) |=>
      (state_q == S_LINK) ##1 out_valid_q)
    else $error("list pop did not complete");

  // Failed requests carry no grant
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q != STAT_OK)) |-> (granted_q == '0) && (offset_q == '0))
    else $error("grant reported on failed request");

endmodule

FILE: sim/fixed_block_pool_allocator_top_tb.sv
`timescale 1ns / 1ps

module fixed_block_pool_allocator_top_tb;
  import fbpa_pkg::*;

  localparam int unsigned NumBlocks  = POOL_BLOCKS_DEF;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned SegItems   = 95;
  localparam int unsigned HoldStart  = 250;
  localparam int unsigned HoldCycles = 400;

  typedef struct packed {
    cmd_e              cmd;
    logic [IndexW-1:0] index;
  } pool_req_t;

  typedef struct packed {
    status_e            status;
    logic [IndexW-1:0]  index;
    logic [OffsetW-1:0] offset;
  } grant_t;

  logic               clk         = 1'b0;
  logic               rst_n       = 1'b0;
  logic               cfg_we      = 1'b0;
  cfg_idx_e           cfg_sel     = CFG_BLOCK_SIZE;
  logic [CfgW-1:0]    cfg_data    = '0;
  logic               in_valid    = 1'b0;
  logic               in_stall;
  cmd_e               command     = CMD_ALLOC;
  logic [IndexW-1:0]  block_index = '0;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  logic [StatusW-1:0] status;
  logic [IndexW-1:0]  granted_index;
  logic [OffsetW-1:0] byte_offset;

  // Pool model state
  logic [SizeW-1:0]  model_size;
  logic [CountW-1:0] model_count;
  logic [CountW-1:0] list_head;
  logic [CountW-1:0] link_mem [NumBlocks];
  logic [CountW-1:0] fresh_next;

  pool_req_t req_q[$];
  grant_t    grant_q[$];
  pool_req_t next_req;
  grant_t    want;
  int        reqs_open       = 0;
  int        results_seen    = 0;
  int        hold_left       = 0;
  bit        long_hold_done  = 1'b0;
  bit        no_idle         = 1'b0;
  int        errors          = 0;
  int        cycles          = 0;

  fixed_block_pool_allocator_top u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_sel),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .command_i      (command),
    .block_index_i  (block_index),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .status_o       (status),
    .granted_index_o(granted_index),
    .byte_offset_o  (byte_offset)
  );

  always #5 clk = ~clk;

  // Apply one request to the pool model and return the grant it produces
  function automatic grant_t pool_predict(cmd_e cmd, logic [IndexW-1:0] idx);
    grant_t            g;
    int unsigned       limit;
    longint unsigned   stride;
    g = '{status: STAT_OK, index: '0, offset: '0};
    limit = (model_count > NumBlocks) ? NumBlocks : model_count;
    stride = (model_size < MIN_STRIDE) ? MIN_STRIDE : model_size;
    stride = (stride + BLOCK_ALIGN_DEF - 1) / BLOCK_ALIGN_DEF * BLOCK_ALIGN_DEF;
    if (cmd == CMD_ALLOC) begin
      if (list_head < NumBlocks) begin
        g.index = list_head[IndexW-1:0];
        list_head = link_mem[list_head[IndexW-1:0]];
      end else if (fresh_next < limit) begin
        g.index = fresh_next[IndexW-1:0];
        fresh_next++;
      end else begin
        g.status = STAT_EMPTY;
      end
      if (g.status == STAT_OK) g.offset = OffsetW'(g.index * stride);
    end else if (idx >= limit) begin
      g.status = STAT_BAD_INDEX;
    end else begin
      link_mem[idx] = list_head;
      list_head = {1'b0, idx};
    end
    return g;
  endfunction

  task automatic push_req(cmd_e cmd, int unsigned idx);
    req_q.push_back('{cmd: cmd, index: IndexW'(idx)});
    reqs_open++;
  endtask

  // Wait until every request was taken and every grant came back
  task automatic drain();
    do @(posedge clk); while (reqs_open != 0 || grant_q.size() != 0);
  endtask

  // Write one register while idle; any write empties the pool
  task automatic write_reg(cfg_idx_e sel, logic [CfgW-1:0] value);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_sel  <= sel;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (sel == CFG_BLOCK_SIZE) model_size = value[SizeW-1:0];
    else model_count = value[CountW-1:0];
    list_head  = CountW'(NumBlocks);
    fresh_next = '0;
  endtask

  task automatic reconfigure(logic [CfgW-1:0] size, int unsigned count);
    drain();
    repeat (4) @(posedge clk);
    write_reg(CFG_BLOCK_SIZE, size);
    // upper data bits above the count width are don't-care
    write_reg(CFG_BLOCK_COUNT, {(CfgW-CountW)'($urandom), CountW'(count)});
  endtask

  // Drive requests from the pending queue; predict each one on acceptance
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid    <= 1'b0;
      command     <= CMD_ALLOC;
      block_index <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        grant_q.push_back(pool_predict(command, block_index));
        reqs_open--;
      end
      if (!in_valid || !in_stall) begin
        if (req_q.size() != 0 && (no_idle || $urandom_range(99) >= 16)) begin
          next_req = req_q.pop_front();
          in_valid    <= 1'b1;
          command     <= next_req.cmd;
          block_index <= next_req.index;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Check grants in order and stall the output at random
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (grant_q.size() == 0) begin
          $error("grant with nothing pending: status %0d index %0d offset %0d",
                 status, granted_index, byte_offset);
          errors++;
        end else begin
          want = grant_q.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            errors++;
          end
          if (granted_index !== want.index) begin
            $error("granted_index: expected %0d, got %0d", want.index, granted_index);
            errors++;
          end
          if (byte_offset !== want.offset) begin
            $error("byte_offset: expected %0d, got %0d", want.offset, byte_offset);
            errors++;
          end
        end
      end
      // hold the output off once for a long stretch so the block backs up
      if (!long_hold_done && results_seen >= HoldStart) begin
        long_hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !no_idle && ($urandom_range(99) < 16);
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("fixed_block_pool_allocator_top_tb failed");
      $finish;
    end
  end

  initial begin
    int unsigned       size;
    int unsigned       count;
    int unsigned       eff;
    int unsigned       alloc_pct;
    logic [IndexW-1:0] idx;
    cmd_e              cmd;

    model_size  = BLOCK_SIZE_RST;
    model_count = BLOCK_COUNT_RST;
    list_head   = CountW'(NumBlocks);
    fresh_next  = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Fresh allocs, then LIFO reuse of freed blocks
    push_req(CMD_ALLOC, 0);
    push_req(CMD_ALLOC, 1023);
    push_req(CMD_ALLOC, 0);
    push_req(CMD_FREE, 1);
    push_req(CMD_FREE, 2);
    push_req(CMD_ALLOC, 0);
    push_req(CMD_ALLOC, 0);
    push_req(CMD_ALLOC, 0);
    // Free a block never handed out, then a double free
    push_req(CMD_FREE, 1023);
    push_req(CMD_ALLOC, 0);
    push_req(CMD_FREE, 0);
    push_req(CMD_FREE, 0);
    push_req(CMD_ALLOC, 0);
    push_req(CMD_ALLOC, 0);

    // Empty pool: every alloc empty, every free a bad index
    reconfigure(8, 0);
    push_req(CMD_ALLOC, 0);
    push_req(CMD_FREE, 0);
    push_req(CMD_FREE, 1023);

    // Zero size raised to the minimum stride; small pool runs dry
    reconfigure(0, 3);
    repeat (4) push_req(CMD_ALLOC, 0);
    push_req(CMD_FREE, 3);
    push_req(CMD_FREE, 2);
    push_req(CMD_ALLOC, 0);

    // Largest size and an oversized count; offset wraps at its width
    reconfigure(17'h1FFFF, 2047);
    push_req(CMD_FREE, 1023);
    push_req(CMD_ALLOC, 0);
    push_req(CMD_ALLOC, 0);

    // Random segments, each under its own configuration
    for (int seg = 0; seg < 5; seg++) begin
      case (seg)
        0: begin
          size = $urandom_range(1, 64);
          count = 1024;
          alloc_pct = 50;
        end
        1: begin
          size = 17'h1FFFF;
          count = 2047;
          alloc_pct = 55;
        end
        2: begin
          size = $urandom_range(0, 17'h1FFFF);
          count = $urandom_range(1, 16);
          alloc_pct = 55;
        end
        3: begin
          size = 65536;
          count = $urandom_range(0, 2);
          alloc_pct = 50;
        end
        default: begin
          size = $urandom_range(0, 7);
          count = $urandom_range(1, 2047);
          alloc_pct = 45;
        end
      endcase
      reconfigure(SizeW'(size), count);
      no_idle = (seg == 3);
      eff = (count > NumBlocks) ? NumBlocks : count;
      for (int n = 0; n < SegItems; n++) begin
        cmd = ($urandom_range(99) < alloc_pct) ? CMD_ALLOC : CMD_FREE;
        case ($urandom_range(3))
          0, 1: idx = (eff == 0) ? '0 : IndexW'($urandom_range(eff - 1));
          2: idx = IndexW'($urandom_range((eff > 1023) ? 1023 : eff));
          default: idx = IndexW'($urandom);
        endcase
        push_req(cmd, idx);
      end
    end

    drain();
    no_idle = 1'b0;
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("fixed_block_pool_allocator_top_tb passed");
    end else begin
      $display("fixed_block_pool_allocator_top_tb failed");
    end
    $finish;
  end

endmodule
